[rtl/core/nmea_pkg.sv]
// Package for the NMEA RMC position extractor: sentence phase codes,
// result kinds, the header character table and the result struct.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package nmea_pkg;

    // Sentence walk phases, one-hot.
    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_STATUS = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_FIELDS = 5'b10000
    } t_phase;

    // Kind of a result transfer.
    typedef enum logic [1:0] {
        KIND_LAT = 2'd0,
        KIND_LON = 2'd1,
        KIND_FIX = 2'd2
    } t_kind;

    // Characters of interest in the stream.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_VOID   = 8'h56;
    localparam logic [7:0] CH_ACTIVE = 8'h41;

    // Last header index; comma counts of lat, lon and end of speed.
    localparam logic [2:0] HDR_LAST    = 3'd5;
    localparam logic [2:0] COMMA_LAT   = 3'd0;
    localparam logic [2:0] COMMA_LON   = 3'd2;
    localparam logic [2:0] COMMA_FINAL = 3'd5;

    // One result decided for one byte.
    typedef struct packed {
        logic        emit;
        t_kind       kind;
        logic [7:0]  ch;
    } t_result;

    // Expected header character "GPRMC," at a given match position.
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h52; // R
            3'd3:    c = 8'h4D; // M
            3'd4:    c = 8'h43; // C
            3'd5:    c = 8'h2C; // ,
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/nmea_fsm.sv]
// Sentence tracker for the NMEA RMC position extractor: holds the phase,
// header match position and comma count, and decides the result of a byte.
// Depends on nmea_pkg.
`default_nettype none

module nmea_fsm (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte,
    output nmea_pkg::t_result      o_result
);
    import nmea_pkg::*;

    t_phase     r_phase, n_phase;
    logic [2:0] r_hdr_idx, n_hdr_idx;
    logic [2:0] r_commas, n_commas;
    logic [2:0] commas_inc;
    t_result    res;

    assign commas_inc = r_commas + 3'd1;

    // Next state and result for the byte held at the input register.
    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_commas  = r_commas;
        res.emit  = 1'b0;
        res.kind  = KIND_LAT;
        res.ch    = 8'h00;
        case (r_phase)
            PH_HEADER: begin
                if (i_byte == CH_DOLLAR) begin
                    n_hdr_idx = 3'd0;
                end else if (r_hdr_idx <= HDR_LAST && i_byte == hdr_char(r_hdr_idx)) begin
                    if (r_hdr_idx == HDR_LAST) begin
                        n_hdr_idx = 3'd0;
                        n_phase   = PH_STATUS;
                    end else begin
                        n_hdr_idx = r_hdr_idx + 3'd1;
                    end
                end else begin
                    n_hdr_idx = 3'd0;
                    n_phase   = PH_HUNT;
                end
            end
            PH_STATUS: begin
                if (i_byte == CH_VOID) begin
                    n_phase = PH_HUNT;
                end else if (i_byte == CH_ACTIVE) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_commas = 3'd0;
                n_phase  = PH_FIELDS;
            end
            PH_FIELDS: begin
                if (i_byte == CH_COMMA) begin
                    if (commas_inc >= COMMA_FINAL) begin
                        // The comma that ends the speed field completes the fix.
                        n_commas = 3'd0;
                        n_phase  = PH_HUNT;
                        res.emit = 1'b1;
                        res.kind = KIND_FIX;
                    end else begin
                        n_commas = commas_inc;
                    end
                end else if (r_commas == COMMA_LAT) begin
                    res.emit = 1'b1;
                    res.kind = KIND_LAT;
                    res.ch   = i_byte;
                end else if (r_commas == COMMA_LON) begin
                    res.emit = 1'b1;
                    res.kind = KIND_LON;
                    res.ch   = i_byte;
                end
            end
            default: begin
                // Hunting, and any code that is not a phase.
                n_hdr_idx = 3'd0;
                n_commas  = 3'd0;
                n_phase   = (i_byte == CH_DOLLAR) ? PH_HEADER : PH_HUNT;
            end
        endcase
    end

    assign o_result = res;

    // State advances only when the byte moves on to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hdr_idx <= 3'd0;
            r_commas  <= 3'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_commas  <= n_commas;
        end
    end

    // The header position is only nonzero while the header is being matched.
    a_hdr_idx_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEADER |-> r_hdr_idx == 3'd0)
        else $error("header index nonzero outside header match");

    // The comma count never reaches the completion count.
    a_commas_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_commas < COMMA_FINAL)
        else $error("comma count out of range");

    // A completion marker always sends the block back to hunting.
    a_fix_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.emit && res.kind == KIND_FIX |=> r_phase == PH_HUNT)
        else $error("fix marker without return to hunting");

endmodule

`default_nettype wire

[rtl/core/nmea_rmc_position_extractor.sv]
// Top level of the NMEA RMC position extractor: input register, sentence
// tracker and result register with valid/stall handshakes.
// Depends on nmea_pkg and nmea_fsm.
`default_nettype none

// The block takes one received serial byte per transfer and follows the
// GPS stream for "$GPRMC," sentences with an active ('A') status. For each
// latitude and longitude character it delivers one result transfer (kind 0
// or 1 with the character), and at the comma that closes the speed field it
// delivers a completion marker (kind 2, character zero). All other bytes
// produce no result. Throughput is one byte per clock cycle while the
// receiver does not stall; a byte passes an input register and then a
// result register, from which its result is offered to the receiver.
// The sentence tracker is the only stage with state, and it advances once
// per byte as the byte enters the result stage.
module nmea_rmc_position_extractor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_ch
);
    import nmea_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_ch;

    logic       out_free;
    logic       advance;
    logic       in_take;
    t_result    result;

    // The result stage can take a byte when empty or when its result leaves.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nmea_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.emit && out_free) begin
            r_out_kind <= result.kind;
            r_out_ch   <= result.ch;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_ch        = r_out_ch;

    // A completion marker carries no character.
    a_fix_ch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_FIX |-> r_out_ch == 8'h00)
        else $error("completion marker with nonzero character");

    // A byte held at the input register is not lost or replaced.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("held input byte lost");

    // A result waiting under stall is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_kind)
            && $stable(r_out_ch))
        else $error("stalled result changed");

endmodule

`default_nettype wire

[tb/nmea_rmc_position_extractor_test.sv]
// Self-checking testbench for nmea_rmc_position_extractor: directed RMC sentences,
// then random sentence traffic with sender gaps and receiver stalls.
// Depends on nmea_pkg and the RTL under rtl/core.
module nmea_rmc_position_extractor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nmea_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;

    localparam logic [7:0] RMC_HEADER [0:5] = '{"G", "P", "R", "M", "C", ","};

    // One expected result transfer.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_fix_char;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_ch;

    // Sentence tracker mirror and the results it still owes.
    t_phase     rmc_phase    = PH_HUNT;
    logic [2:0] hdr_pos      = '0;
    logic [2:0] commas_seen  = '0;
    t_fix_char  pending_fix_chars[$];

    int fail_count    = 0;
    int stream_bytes  = 0;
    int idle_cycles   = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;

    nmea_rmc_position_extractor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_ch        (o_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Advance the sentence tracker by one byte and queue any result it causes.
    function automatic void track_rmc_byte(input logic [7:0] b);
        t_fix_char res;
        case (rmc_phase)
            PH_HEADER: begin
                if (b == CH_DOLLAR) begin
                    hdr_pos = '0;
                end else if (b == RMC_HEADER[hdr_pos]) begin
                    if (hdr_pos == HDR_LAST) begin
                        hdr_pos   = '0;
                        rmc_phase = PH_STATUS;
                    end else begin
                        hdr_pos = hdr_pos + 3'd1;
                    end
                end else begin
                    hdr_pos   = '0;
                    rmc_phase = PH_HUNT;
                end
            end
            PH_STATUS: begin
                if (b == CH_VOID) begin
                    rmc_phase = PH_HUNT;
                end else if (b == CH_ACTIVE) begin
                    rmc_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                commas_seen = '0;
                rmc_phase   = PH_FIELDS;
            end
            PH_FIELDS: begin
                if (b == CH_COMMA) begin
                    commas_seen = commas_seen + 3'd1;
                    if (commas_seen >= COMMA_FINAL) begin
                        commas_seen = '0;
                        rmc_phase   = PH_HUNT;
                        res.kind    = KIND_FIX;
                        res.ch      = 8'h00;
                        pending_fix_chars.push_back(res);
                    end
                end else if (commas_seen == COMMA_LAT) begin
                    res.kind = KIND_LAT;
                    res.ch   = b;
                    pending_fix_chars.push_back(res);
                end else if (commas_seen == COMMA_LON) begin
                    res.kind = KIND_LON;
                    res.ch   = b;
                    pending_fix_chars.push_back(res);
                end
            end
            default: begin
                hdr_pos     = '0;
                commas_seen = '0;
                rmc_phase   = (b == CH_DOLLAR) ? PH_HEADER : PH_HUNT;
            end
        endcase
    endfunction

    // A random field character; never a comma, sometimes a dollar sign.
    function automatic logic [7:0] field_byte();
        logic [7:0] b;
        if ($urandom_range(15) == 0) return CH_DOLLAR;
        do b = 8'($urandom_range(255)); while (b == CH_COMMA);
        return b;
    endfunction

    // Offer one byte, with random gaps before it, and wait for its transfer.
    task automatic send_byte(input logic [7:0] b, input bit counts);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        track_rmc_byte(b);
        if (counts) stream_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1);
    endtask

    // Hold the sender off until every owed result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_fix_chars.size() != 0) @(posedge i_clk);
    endtask

    // One sentence: mostly well formed with random content, sometimes broken or noise.
    task automatic send_random_sentence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), 1'b0);
            return;
        end
        send_byte(CH_DOLLAR, 1'b1);
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(39) == 0) begin
                send_byte(8'($urandom_range(255)), 1'b1);
                return;
            end
            send_byte(RMC_HEADER[i], 1'b1);
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)), 1'b0);
        if ($urandom_range(9) < 2) begin
            send_byte(CH_VOID, 1'b1);
            return;
        end
        send_byte(CH_ACTIVE, 1'b1);
        send_byte(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : CH_COMMA, 1'b1);
        for (int f = 0; f < 5; f++) begin
            repeat ($urandom_range(0, 4)) send_byte(field_byte(), 1'b1);
            if ($urandom_range(49) == 0) return;
            send_byte(CH_COMMA, 1'b1);
        end
    endtask

    // Active fix: header restart on a dollar, ignored status noise, any byte after
    // the status, extreme and dollar data, skipped hemisphere, empty speed field.
    task automatic test_active_fix();
        send_text("$G$GPRMC,ZA");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_text("$,N,");
        send_byte(8'hFF, 1'b1);
        send_text(",,,");
    endtask

    // A void status drops the sentence without any result.
    task automatic test_void_status();
        send_text("$GPRMC,V");
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input int n_bytes);
        int target;
        gap_pct   = gap;
        stall_pct = stall;
        target    = stream_bytes + n_bytes;
        while (stream_bytes < target) send_random_sentence();
    endtask

    // Sentences separated by full drains of the result side.
    task automatic test_drain_pause();
        gap_pct   = 20;
        stall_pct = 50;
        repeat (3) begin
            send_random_sentence();
            drain_results();
        end
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each result transfer with the oldest owed result.
    always @(posedge i_clk) begin
        t_fix_char want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_fix_chars.size() == 0) begin
                $error("unexpected result transfer: kind %0d ch %02h", o_kind, o_ch);
                fail_count++;
            end else begin
                want = pending_fix_chars.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                    fail_count++;
                end
                if (o_ch !== want.ch) begin
                    $error("ch: expected %02h, actual %02h", want.ch, o_ch);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("nmea_rmc_position_extractor verification failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_active_fix();
        test_void_status();
        test_random_traffic(0, 0, 220);
        test_random_traffic(75, 0, 220);
        test_drain_pause();
        test_random_traffic(0, 75, 220);
        test_random_traffic(9, 9, 220);

        // Let every owed result arrive, then watch for stray ones.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("nmea_rmc_position_extractor verification clean");
        else
            $display("nmea_rmc_position_extractor verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/nmea_pkg.sv
rtl/core/nmea_fsm.sv
rtl/core/nmea_rmc_position_extractor.sv
tb/nmea_rmc_position_extractor_test.sv
